@@ rtl/blpg_pkg.sv @@
// Shared types, constants and helpers for the line pixel generator.
package blpg_pkg;

    localparam int DIM_BITS       = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int ADDR_BITS      = 24;
    localparam int COLOR_565_BITS = 16;
    localparam int ARGB_BITS      = 32;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 13'd960;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 13'd544;
    localparam logic [7:0]          ALPHA_OPAQUE     = 8'hFF;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    // RGB565 to opaque ARGB32, zero fill in the low bits of each channel
    function automatic logic [ARGB_BITS-1:0] expand_565(input logic [COLOR_565_BITS-1:0] c);
        expand_565 = {ALPHA_OPAQUE, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

endpackage

@@ rtl/blpg_if.sv @@
// Channel interfaces: configuration writes, commands and pixel results.
interface blpg_cfg_if;
    import blpg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface blpg_cmd_if #(parameter int COORD_BITS = 16);
    import blpg_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_565_BITS-1:0]    color_565;
    modport source (output valid, func, start_x, start_y, end_x, end_y, color_565,
                    input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, color_565,
                    output ready);
endinterface

interface blpg_pix_if #(parameter int COORD_BITS = 16);
    import blpg_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         write_enable;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [ARGB_BITS-1:0]         color_argb;
    logic                         last;
    modport source (output valid, pixel_x, pixel_y, write_enable, pixel_address,
                    color_argb, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, write_enable, pixel_address,
                    color_argb, last, output ready);
endinterface

@@ rtl/bresenham_line_pixel_generator_top.sv @@
// Top level of the all-octant line pixel generator.
//
//  channel  | dir | payload                                           | accepted when
//  ---------+-----+---------------------------------------------------+---------------
//  i_cfg    | in  | index, data (frame_width / frame_height)          | valid & ready
//  i_cmd    | in  | func, start_x, start_y, end_x, end_y, color_565   | valid & ready
//  o_pix    | out | pixel_x/y, write_enable, pixel_address, argb, last | valid & ready
//
// One pixel per clock unless o_pix stalls: every command transaction yields
// exactly one result, registered in the next cycle. The line state and the output
// register load on the same edge, so commands stream back to back; the rate is
// set by the single error-term update and the 13x13 address multiply ahead of o_pix.
// Reset is synchronous and active low; it restores the frame size and drops any
// active line. Outside reset, i_cmd.ready falls only while o_pix.ready holds a result.
module bresenham_line_pixel_generator_top #(
    parameter int COORD_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blpg_cfg_if.sink   i_cfg,
    blpg_cmd_if.sink   i_cmd,
    blpg_pix_if.source o_pix
);
    import blpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] COORD_ONE = CB'(1);

    // configuration
    logic [DIM_BITS-1:0] r_frame_width;
    logic [DIM_BITS-1:0] r_frame_height;

    // line state
    logic signed [CB-1:0] r_cur_x,  n_cur_x;
    logic signed [CB-1:0] r_cur_y,  n_cur_y;
    logic signed [CB-1:0] r_tgt_x,  n_tgt_x;
    logic signed [CB-1:0] r_tgt_y,  n_tgt_y;
    logic [CB:0]          r_delta_x, n_delta_x;
    logic signed [CB+1:0] r_neg_delta_y, n_neg_delta_y;
    logic                 r_step_x_neg, n_step_x_neg;
    logic                 r_step_y_neg, n_step_y_neg;
    logic signed [CB+2:0] r_error, n_error;
    logic [ARGB_BITS-1:0] r_line_color, n_line_color;
    logic                 r_line_active, n_line_active;

    // output register
    logic                 r_out_valid;
    logic signed [CB-1:0] r_out_x;
    logic signed [CB-1:0] r_out_y;
    logic                 r_out_we;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [ARGB_BITS-1:0] r_out_color;
    logic                 r_out_last;

    logic cmd_accept;
    logic is_start;
    logic em_en;
    logic em_last;
    logic em_we;
    logic [ADDR_BITS-1:0] em_addr;

    // start set-up
    logic signed [CB:0]   s_x1, s_y1, s_x2, s_y2;
    logic [CB:0]          s_dx;
    logic signed [CB:0]   s_ndy;
    logic signed [CB+2:0] s_err;

    // step
    logic signed [CB+3:0] k_e2, k_ndy, k_dx;
    logic                 k_mv_x, k_mv_y;
    logic signed [CB+2:0] k_add_x, k_add_y;

    assign i_cfg.ready = i_rst_n;
    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_pix.ready);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign is_start    = (i_cmd.func == FUNC_START);

    assign s_x1  = {i_cmd.start_x[CB-1], i_cmd.start_x};
    assign s_y1  = {i_cmd.start_y[CB-1], i_cmd.start_y};
    assign s_x2  = {i_cmd.end_x[CB-1], i_cmd.end_x};
    assign s_y2  = {i_cmd.end_y[CB-1], i_cmd.end_y};
    assign s_dx  = (s_x2 >= s_x1) ? (s_x2 - s_x1) : (s_x1 - s_x2);
    assign s_ndy = (s_y2 >= s_y1) ? (s_y1 - s_y2) : (s_y2 - s_y1);
    assign s_err = $signed({2'b00, s_dx}) + {{2{s_ndy[CB]}}, s_ndy};

    // decision on twice the error, both axes may move in one step
    assign k_e2    = {r_error, 1'b0};
    assign k_ndy   = {{2{r_neg_delta_y[CB+1]}}, r_neg_delta_y};
    assign k_dx    = $signed({3'b000, r_delta_x});
    assign k_mv_x  = (k_e2 >= k_ndy);
    assign k_mv_y  = (k_e2 <= k_dx);
    assign k_add_x = k_mv_x ? {r_neg_delta_y[CB+1], r_neg_delta_y} : '0;
    assign k_add_y = k_mv_y ? $signed({2'b00, r_delta_x}) : '0;

    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_tgt_x       = r_tgt_x;
        n_tgt_y       = r_tgt_y;
        n_delta_x     = r_delta_x;
        n_neg_delta_y = r_neg_delta_y;
        n_step_x_neg  = r_step_x_neg;
        n_step_y_neg  = r_step_y_neg;
        n_error       = r_error;
        n_line_color  = r_line_color;
        n_line_active = r_line_active;
        em_en         = 1'b0;
        em_last       = 1'b1;
        if (cmd_accept) begin
            if (is_start) begin
                n_cur_x       = i_cmd.start_x;
                n_cur_y       = i_cmd.start_y;
                n_tgt_x       = i_cmd.end_x;
                n_tgt_y       = i_cmd.end_y;
                n_delta_x     = s_dx;
                n_neg_delta_y = {s_ndy[CB], s_ndy};
                n_step_x_neg  = !(s_x1 < s_x2);
                n_step_y_neg  = !(s_y1 < s_y2);
                n_error       = s_err;
                n_line_color  = expand_565(i_cmd.color_565);
                em_en         = 1'b1;
                em_last       = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
                n_line_active = !em_last;
            end else if (r_line_active) begin
                n_error = r_error + k_add_x + k_add_y;
                if (k_mv_x) begin
                    n_cur_x = r_step_x_neg ? (r_cur_x - COORD_ONE) : (r_cur_x + COORD_ONE);
                end
                if (k_mv_y) begin
                    n_cur_y = r_step_y_neg ? (r_cur_y - COORD_ONE) : (r_cur_y + COORD_ONE);
                end
                em_en         = 1'b1;
                em_last       = (n_cur_x == r_tgt_x) && (n_cur_y == r_tgt_y);
                n_line_active = !em_last;
            end
            // idle step: state held, disabled pixel flagged last
        end
    end

    blpg_clip #(
        .COORD_BITS (COORD_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_clip (
        .i_en           (em_en),
        .i_x            (n_cur_x),
        .i_y            (n_cur_y),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_we           (em_we),
        .o_addr         (em_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_tgt_x       <= '0;
            r_tgt_y       <= '0;
            r_delta_x     <= '0;
            r_neg_delta_y <= '0;
            r_step_x_neg  <= 1'b0;
            r_step_y_neg  <= 1'b0;
            r_error       <= '0;
            r_line_color  <= '0;
            r_line_active <= 1'b0;
        end else begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_tgt_x       <= n_tgt_x;
            r_tgt_y       <= n_tgt_y;
            r_delta_x     <= n_delta_x;
            r_neg_delta_y <= n_neg_delta_y;
            r_step_x_neg  <= n_step_x_neg;
            r_step_y_neg  <= n_step_y_neg;
            r_error       <= n_error;
            r_line_color  <= n_line_color;
            r_line_active <= n_line_active;
        end
    end

    // output register: refills on the edge the held result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_pix.ready) begin
            r_out_valid <= cmd_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_out_x     <= n_cur_x;
            r_out_y     <= n_cur_y;
            r_out_we    <= em_we;
            r_out_addr  <= em_addr;
            r_out_color <= n_line_color;
            r_out_last  <= em_last;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_x       = r_out_x;
    assign o_pix.pixel_y       = r_out_y;
    assign o_pix.write_enable  = r_out_we;
    assign o_pix.pixel_address = r_out_addr;
    assign o_pix.color_argb    = r_out_color;
    assign o_pix.last          = r_out_last;

endmodule

@@ rtl/blpg_clip.sv @@
// Framebuffer clip test and linear address y*width+x.
module blpg_clip #(
    parameter int COORD_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  logic                           i_en,
    input  logic signed [COORD_BITS-1:0]   i_x,
    input  logic signed [COORD_BITS-1:0]   i_y,
    input  logic [blpg_pkg::DIM_BITS-1:0]  i_frame_width,
    input  logic [blpg_pkg::DIM_BITS-1:0]  i_frame_height,
    output logic                           o_we,
    output logic [blpg_pkg::ADDR_BITS-1:0] o_addr
);
    import blpg_pkg::*;

    logic [DIM_BITS-1:0]   w_cl;
    logic [DIM_BITS-1:0]   h_cl;
    logic [31:0]           x_ext;
    logic [31:0]           y_ext;
    logic                  in_frame;
    logic [2*DIM_BITS-1:0] prod;
    logic [2*DIM_BITS-1:0] sum;

    assign w_cl = (32'(i_frame_width) > MAX_DIM) ? DIM_BITS'(MAX_DIM) : i_frame_width;
    assign h_cl = (32'(i_frame_height) > MAX_DIM) ? DIM_BITS'(MAX_DIM) : i_frame_height;

    assign x_ext = {{(32-COORD_BITS){1'b0}}, i_x};
    assign y_ext = {{(32-COORD_BITS){1'b0}}, i_y};

    // negative coordinates fail on the sign bit before the unsigned compare
    assign in_frame = i_en && !i_x[COORD_BITS-1] && !i_y[COORD_BITS-1]
                      && (x_ext < 32'(w_cl)) && (y_ext < 32'(h_cl));

    assign prod   = y_ext[DIM_BITS-1:0] * w_cl;
    assign sum    = prod + {{DIM_BITS{1'b0}}, x_ext[DIM_BITS-1:0]};
    assign o_we   = in_frame;
    assign o_addr = in_frame ? sum[ADDR_BITS-1:0] : '0;

endmodule

@@ rtl/blpg_checker.sv @@
// Port-level checks for the line pixel generator, bound to the top level.
module blpg_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cmd_valid,
    input logic                           i_cmd_ready,
    input logic                           i_pix_valid,
    input logic                           i_pix_ready,
    input logic signed [COORD_BITS-1:0]   i_pixel_x,
    input logic signed [COORD_BITS-1:0]   i_pixel_y,
    input logic                           i_write_enable,
    input logic [blpg_pkg::ADDR_BITS-1:0] i_pixel_address,
    input logic                           i_last
);
    import blpg_pkg::*;

    // every command transaction shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> i_pix_valid)
        else $error("command transaction without a result");

    // a stalled result holds its coordinates, write enable, address and last flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_pix_ready) |=> (i_pix_valid && $stable(i_pixel_x)
            && $stable(i_pixel_y) && $stable(i_write_enable)
            && $stable(i_pixel_address) && $stable(i_last)))
        else $error("stalled result changed");

    // commands flow whenever the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix_valid |-> i_cmd_ready)
        else $error("command stalled with empty output");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_write_enable) |-> (i_pixel_address == '0))
        else $error("address set on a masked pixel");

    a_we_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_write_enable) |->
            (!i_pixel_x[COORD_BITS-1] && !i_pixel_y[COORD_BITS-1]))
        else $error("write enabled on a negative coordinate");

endmodule

bind bresenham_line_pixel_generator_top blpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_blpg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_pix_valid     (o_pix.valid),
    .i_pix_ready     (o_pix.ready),
    .i_pixel_x       (o_pix.pixel_x),
    .i_pixel_y       (o_pix.pixel_y),
    .i_write_enable  (o_pix.write_enable),
    .i_pixel_address (o_pix.pixel_address),
    .i_last          (o_pix.last)
);
